// ===== hw/rtl/sks_pkg.sv =====
`default_nettype none

package sks_pkg;

    localparam int SET_DEPTH = 16;
    localparam int IDX_W     = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam int CNT_W     = $clog2(SET_DEPTH + 1);
    localparam int CAP_W     = 5;
    localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int ID_W      = 32;
    localparam int MAJOR_W   = 16;
    localparam int KEY_W     = ID_W + MAJOR_W;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic [1:0] {
        OP_OPEN     = 2'd0,
        OP_INSERT   = 2'd1,
        OP_CONTAINS = 2'd2,
        OP_CLOSE    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_DUP     = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sorted_key_set.sv =====
// Sorted key set: (id, major) keys kept in ascending order in a single-port-write RAM.
// Open, close, a bad key, a closed set or an empty set go from idle straight to the done
// state. Insert/contains scan one entry a cycle (up to entries_held entries); an insert
// then shifts one entry a cycle down to its slot and places it. The done state raises
// m_tvalid once the result channel is free. One request at a time.
// Synchronous active-low reset empties and closes the set, capacity_limit 16; RAM kept.
`default_nettype none

module sorted_key_set (
    input  wire                      aclk,
    input  wire                      aresetn,
    // request channel
    input  wire                      s_tvalid,
    output logic                     s_tready,
    input  wire [sks_pkg::KEY_W-1:0] s_tdata,   // [31:0] key_id, [47:32] key_major
    input  wire [1:0]                s_tuser,   // [1:0] opcode
    // result channel
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [sks_pkg::M_TDATA_W-1:0] m_tdata, // [4:0] entries_held, [7:5] zero
    output logic [sks_pkg::M_TUSER_W-1:0] m_tuser, // [1:0] status, [2] present
    // capacity_limit write channel
    input  wire                      cfg_valid,
    output logic                     cfg_ready,
    input  wire [sks_pkg::CAP_W-1:0] cfg_data
);
    import sks_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_PLACE,
        S_DONE
    } state_t;

    // key store: {id, major} so a plain compare gives lexicographic order
    logic [KEY_W-1:0] key_mem [SET_DEPTH];
    logic [KEY_W-1:0] rd_data_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    logic [KEY_W-1:0] mem_wdata;

    // control
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             open_reg, open_next;
    logic [CAP_W-1:0] cap_reg, cap_next;
    logic             m_tvalid_reg, m_tvalid_next;

    // request and result payload
    opcode_t          op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    status_t          res_status_reg, res_status_next;
    logic             res_present_reg, res_present_next;
    status_t          m_status_reg, m_status_next;
    logic             m_present_reg, m_present_next;
    logic [CAP_W-1:0] m_held_reg, m_held_next;

    logic [KEY_W-1:0] in_key;
    opcode_t          in_op;
    logic             in_valid_key;
    logic             set_full;
    logic [CNT_W-1:0] pos_inc;
    logic [CNT_W-1:0] slot;
    logic             key_less;
    logic             key_equal;

    assign in_key       = {s_tdata[ID_W-1:0], s_tdata[KEY_W-1:ID_W]};
    assign in_op        = opcode_t'(s_tuser);
    assign in_valid_key = (s_tdata[ID_W-1:0] != '0) && (s_tdata[KEY_W-1:ID_W] != '0);

    // full against the lower of capacity_limit and the built depth
    assign set_full = (count_reg >= CNT_W'(SET_DEPTH)) ||
                      (CMP_W'(count_reg) >= CMP_W'(cap_reg));

    assign pos_inc   = CNT_W'(pos_reg + 1'b1);
    assign key_less  = rd_data_reg < key_reg;
    assign key_equal = rd_data_reg == key_reg;
    assign slot      = key_less ? pos_inc : pos_reg;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = M_TDATA_W'(m_held_reg);
    assign m_tuser   = {m_present_reg, m_status_reg};

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        open_next        = open_reg;
        cap_next         = cap_reg;
        m_tvalid_next    = m_tvalid_reg;
        op_next          = op_reg;
        key_next         = key_reg;
        pos_next         = pos_reg;
        idx_next         = idx_reg;
        res_status_next  = res_status_reg;
        res_present_next = res_present_reg;
        m_status_next    = m_status_reg;
        m_present_next   = m_present_reg;
        m_held_next      = m_held_reg;
        mem_we           = 1'b0;
        mem_waddr        = idx_reg;
        mem_wdata        = rd_data_reg;
        mem_raddr        = '0;

        if (cfg_valid) begin
            cap_next = cfg_data;
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next          = in_op;
                    key_next         = in_key;
                    pos_next         = '0;
                    res_status_next  = ST_OK;
                    res_present_next = 1'b0;
                    state_next       = S_DONE;
                    case (in_op)
                        OP_OPEN: begin
                            if (open_reg) begin
                                res_status_next = ST_DUP;
                            end else begin
                                count_next = '0;
                                open_next  = 1'b1;
                            end
                        end
                        OP_CLOSE: begin
                            count_next = '0;
                            open_next  = 1'b0;
                        end
                        default: begin
                            if (!open_reg || !in_valid_key) begin
                                res_status_next = ST_INVALID;
                            end else if (count_reg != '0) begin
                                // entry 0 is being read this cycle
                                state_next = S_SCAN;
                            end else if (in_op == OP_INSERT) begin
                                if (set_full) begin
                                    res_status_next = ST_FULL;
                                end else begin
                                    mem_we     = 1'b1;
                                    mem_waddr  = '0;
                                    mem_wdata  = in_key;
                                    count_next = CNT_W'(1);
                                end
                            end
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (key_less && (pos_inc != count_reg)) begin
                    pos_next  = pos_inc;
                    mem_raddr = pos_inc[IDX_W-1:0];
                end else begin
                    pos_next   = slot;
                    state_next = S_DONE;
                    if (op_reg == OP_CONTAINS) begin
                        res_present_next = key_equal;
                    end else if (key_equal) begin
                        res_status_next = ST_DUP;
                    end else if (set_full) begin
                        res_status_next = ST_FULL;
                    end else if (slot == count_reg) begin
                        // goes on the end, nothing to move
                        mem_we     = 1'b1;
                        mem_waddr  = slot[IDX_W-1:0];
                        mem_wdata  = key_reg;
                        count_next = CNT_W'(count_reg + 1'b1);
                    end else begin
                        idx_next   = count_reg[IDX_W-1:0];
                        mem_raddr  = IDX_W'(count_reg - 1'b1);
                        state_next = S_SHIFT;
                    end
                end
            end

            S_SHIFT: begin
                // move entry idx-1 up to idx, read the next one down
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = rd_data_reg;
                if (IDX_W'(idx_reg - 1'b1) == pos_reg[IDX_W-1:0]) begin
                    state_next = S_PLACE;
                end else begin
                    idx_next  = IDX_W'(idx_reg - 1'b1);
                    mem_raddr = IDX_W'(idx_reg - 2'd2);
                end
            end

            S_PLACE: begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg[IDX_W-1:0];
                mem_wdata  = key_reg;
                count_next = CNT_W'(count_reg + 1'b1);
                state_next = S_DONE;
            end

            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next  = 1'b1;
                    m_status_next  = res_status_reg;
                    m_present_next = res_present_reg;
                    m_held_next    = CAP_W'(count_reg);
                    state_next     = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            open_reg     <= 1'b0;
            cap_reg      <= CAP_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            open_reg     <= open_next;
            cap_reg      <= cap_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        op_reg          <= op_next;
        key_reg         <= key_next;
        pos_reg         <= pos_next;
        idx_reg         <= idx_next;
        res_status_reg  <= res_status_next;
        res_present_reg <= res_present_next;
        m_status_reg    <= m_status_next;
        m_present_reg   <= m_present_next;
        m_held_reg      <= m_held_next;
    end

    // key RAM, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= key_mem[mem_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sks_checker.sv =====
`default_nettype none

module sks_checker (
    input wire                          aclk,
    input wire                          aresetn,
    input wire                          s_tvalid,
    input wire                          s_tready,
    input wire                          m_tvalid,
    input wire                          m_tready,
    input wire [sks_pkg::M_TDATA_W-1:0] m_tdata,
    input wire [sks_pkg::M_TUSER_W-1:0] m_tuser
);
    import sks_pkg::*;

    // a stalled result holds
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // no result straight out of reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // one request in flight at a time
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in flight");

    // a hit means a successful lookup in a non-empty set
    a_present_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> (m_tuser[1:0] == ST_OK) && (m_tdata[CAP_W-1:0] != '0))
        else $error("present flagged on failed or empty lookup");

endmodule

bind sorted_key_set sks_checker u_sks_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
